>>> rtl/qrp_pkg.sv
package qrp_pkg;

    localparam int QW          = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 34;
    localparam int S_W         = 32;
    localparam int RAD_W       = 61;
    localparam int ROOT_W      = 31;
    localparam int ISQ_STEPS   = 31;
    localparam int CORDIC_STEPS = 25;
    localparam int XW          = 38;
    localparam int ZW          = 28;
    localparam int ROLL_W      = 16;
    localparam int PITCH_W     = 15;
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_LATENCY = FRONT_STAGES + ISQ_STEPS + CORDIC_STEPS + 2;

    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [SUM_W-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [17:0] ROLL_LIMIT  = 18'sd25736;
    localparam logic signed [17:0] PITCH_LIMIT = 18'sd12868;

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
        28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
        28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
        28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4,
        28'sd2, 28'sd1
    };

    // negate a q.24 angle, round half up to q3.13, clamp to +-limit
    function automatic logic signed [17:0] neg_round_clamp(
        input logic signed [ZW-1:0] a,
        input logic signed [17:0]   limit
    );
        logic signed [ZW:0] t;
        logic signed [17:0] r;
        t = -(ZW+1)'(a) + (ZW+1)'(1024);
        r = 18'(t >>> 11);
        if (r > limit) r = limit;
        if (r < -limit) r = -limit;
        return r;
    endfunction

endpackage

>>> rtl/quaternion_to_roll_pitch_unit.sv
// quaternion to roll/pitch gimbal set-points. one item (w, x, y, z, signed
// q1.15) is taken in every cycle that start is high; busy stays low, so the
// block never pushes back. each item gives one result on o_roll_command
// (signed q3.13 radians) and o_pitch_command (signed q2.13 radians) with
// o_valid high for one cycle. the pipe depth, PIPE_LATENCY, is set by the
// pitch path: the front end's product, sum and radicand registers, a 31-stage
// square root (one root bit per stage), a 26-stage cordic and the output
// register. the roll cordic runs beside the square root and its angle waits
// in a delay line. results cannot be held off: take them in the cycle they
// appear.
module quaternion_to_roll_pitch_unit import qrp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [QW-1:0]      i_quat_w,
    input  logic signed [QW-1:0]      i_quat_x,
    input  logic signed [QW-1:0]      i_quat_y,
    input  logic signed [QW-1:0]      i_quat_z,
    output logic                      o_valid,
    output logic signed [ROLL_W-1:0]  o_roll_command,
    output logic signed [PITCH_W-1:0] o_pitch_command
);
    // front end: products, roll operands, saturated asin argument, radicand
    logic                    f_valid;
    logic signed [SUM_W-1:0] f_rn, f_rd;
    logic signed [S_W-1:0]   f_s;
    logic [RAD_W-1:0]        f_rad;

    // cos of pitch via integer square root, asin argument rides along
    logic                  q_valid;
    logic [ROOT_W-1:0]     q_root;
    logic signed [S_W-1:0] q_s;

    // angles out of the two cordic pipes
    logic                 roll_valid;
    logic signed [ZW-1:0] roll_angle;
    logic                 pitch_valid;
    logic signed [ZW-1:0] pitch_angle;

    // roll angle delay line, matches the square root depth
    logic signed [ZW-1:0] r_roll_dly [ISQ_STEPS];

    logic                     r_valid;
    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;

    assign busy = 1'b0;

    qrp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_valid (f_valid),
        .o_rn    (f_rn),
        .o_rd    (f_rd),
        .o_s     (f_s),
        .o_rad   (f_rad)
    );

    qrp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_rad   (f_rad),
        .i_tag   (f_s),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_tag   (q_s)
    );

    // roll = atan2(rn, rd)
    qrp_cordic u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_x     (XW'(f_rd)),
        .i_y     (XW'(f_rn)),
        .o_valid (roll_valid),
        .o_angle (roll_angle)
    );

    // pitch = asin(s) = atan2(s, sqrt(1 - s^2))
    qrp_cordic u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_x     (XW'({1'b0, q_root})),
        .i_y     (XW'(q_s)),
        .o_valid (pitch_valid),
        .o_angle (pitch_angle)
    );

    // roll_valid leads pitch_valid by the same depth; pitch_valid marks the item
    // idle slots carry a zero angle down the delay line
    always_ff @(posedge i_clk) begin
        r_roll_dly[0] <= roll_valid ? roll_angle : '0;
        for (int k = 1; k < ISQ_STEPS; k++) begin
            r_roll_dly[k] <= r_roll_dly[k-1];
        end
    end

    // output register: negate, round half up, clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= pitch_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_roll  <= ROLL_W'(neg_round_clamp(r_roll_dly[ISQ_STEPS-1], ROLL_LIMIT));
        r_pitch <= PITCH_W'(neg_round_clamp(pitch_angle, PITCH_LIMIT));
    end

    assign o_valid         = r_valid;
    assign o_roll_command  = r_roll;
    assign o_pitch_command = r_pitch;
endmodule

>>> rtl/qrp_front.sv
module qrp_front import qrp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [QW-1:0]     i_w,
    input  logic signed [QW-1:0]     i_x,
    input  logic signed [QW-1:0]     i_y,
    input  logic signed [QW-1:0]     i_z,
    output logic                     o_valid,
    output logic signed [SUM_W-1:0]  o_rn,
    output logic signed [SUM_W-1:0]  o_rd,
    output logic signed [S_W-1:0]    o_s,
    output logic        [RAD_W-1:0]  o_rad
);
    // stage 1: products
    logic r_v1;
    logic signed [PROD_W-1:0] r_wx, r_zy, r_ww, r_xx, r_yy, r_zz, r_xz, r_wy;
    // stage 2: sums
    logic r_v2;
    logic signed [SUM_W-1:0] r_rn2, r_rd2;
    logic signed [S_W-1:0]   r_s2;
    logic signed [SUM_W-1:0] n_rn2, n_rd2, n_sraw;
    logic signed [S_W-1:0]   n_s2;
    // stage 3: radicand
    logic r_v3;
    logic signed [SUM_W-1:0] r_rn3, r_rd3;
    logic signed [S_W-1:0]   r_s3;
    logic        [RAD_W-1:0] r_rad3;
    logic [ROOT_W-1:0] s_abs;
    logic [2*ROOT_W-1:0] sq;

    always_comb begin
        n_rn2  = (SUM_W'(r_wx) + SUM_W'(r_zy)) <<< 1;
        n_rd2  = SUM_W'(r_ww) - SUM_W'(r_xx) - SUM_W'(r_yy) + SUM_W'(r_zz);
        n_sraw = (SUM_W'(r_xz) - SUM_W'(r_wy)) <<< 1;
        if (n_sraw > ONE_Q30) begin
            n_s2 = S_W'(ONE_Q30);
        end else if (n_sraw < -ONE_Q30) begin
            n_s2 = S_W'(-ONE_Q30);
        end else begin
            n_s2 = S_W'(n_sraw);
        end
        s_abs = r_s2[S_W-1] ? ROOT_W'(-r_s2) : ROOT_W'(r_s2);
        sq    = s_abs * s_abs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wx <= i_w * i_x;
        r_zy <= i_z * i_y;
        r_ww <= i_w * i_w;
        r_xx <= i_x * i_x;
        r_yy <= i_y * i_y;
        r_zz <= i_z * i_z;
        r_xz <= i_x * i_z;
        r_wy <= i_w * i_y;
        r_rn2 <= n_rn2;
        r_rd2 <= n_rd2;
        r_s2  <= n_s2;
        r_rn3 <= r_rn2;
        r_rd3 <= r_rd2;
        r_s3  <= r_s2;
        r_rad3 <= RAD_W'((2*ROOT_W)'(1) << 60) - RAD_W'(sq);
    end

    assign o_valid = r_v3;
    assign o_rn    = r_rn3;
    assign o_rd    = r_rd3;
    assign o_s     = r_s3;
    assign o_rad   = r_rad3;
endmodule

>>> rtl/qrp_isqrt.sv
module qrp_isqrt import qrp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [RAD_W-1:0]       i_rad,
    input  logic signed [S_W-1:0]  i_tag,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output logic signed [S_W-1:0]  o_tag
);
    logic                  r_vld  [ISQ_STEPS];
    logic [RAD_W-1:0]      r_rem  [ISQ_STEPS];
    logic [ROOT_W-1:0]     r_root [ISQ_STEPS];
    logic signed [S_W-1:0] r_tag  [ISQ_STEPS];

    for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_step
        localparam int K = ISQ_STEPS - 1 - g;
        logic                  vin;
        logic [RAD_W-1:0]      rem_in;
        logic [ROOT_W-1:0]     root_in;
        logic signed [S_W-1:0] tag_in;
        logic [RAD_W:0]        delta;
        logic [RAD_W-1:0]      n_rem;
        logic [ROOT_W-1:0]     n_root;

        if (g == 0) begin : g_first
            assign vin = i_valid;
            assign rem_in = i_rad;
            assign root_in = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign vin = r_vld[g-1];
            assign rem_in = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign tag_in = r_tag[g-1];
        end

        // trial bit: (2r + 2^k) * 2^k against the remainder
        always_comb begin
            delta = ((RAD_W+1)'(root_in) << (K+1)) + ((RAD_W+1)'(1) << (2*K));
            if ({1'b0, rem_in} >= delta) begin
                n_rem  = RAD_W'({1'b0, rem_in} - delta);
                n_root = root_in | (ROOT_W'(1) << K);
            end else begin
                n_rem  = rem_in;
                n_root = root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem;
            r_root[g] <= n_root;
            r_tag[g]  <= tag_in;
        end
    end

    assign o_valid = r_vld[ISQ_STEPS-1];
    assign o_root  = r_root[ISQ_STEPS-1];
    assign o_tag   = r_tag[ISQ_STEPS-1];
endmodule

>>> rtl/qrp_cordic.sv
module qrp_cordic import qrp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    output logic                  o_valid,
    output logic signed [ZW-1:0]  o_angle
);
    localparam int NS = CORDIC_STEPS + 1;

    logic                 r_vld  [NS];
    logic                 r_zero [NS];
    logic signed [XW-1:0] r_x    [NS];
    logic signed [XW-1:0] r_y    [NS];
    logic signed [ZW-1:0] r_z    [NS];

    // stage 0: fold the left half plane into the right
    logic signed [XW-1:0] n_x0, n_y0;
    logic signed [ZW-1:0] n_z0;
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI_Q24;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI_Q24;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_z[0]    <= n_z0;
        r_zero[0] <= (i_x == 0) && (i_y == 0);
    end

    for (genvar g = 1; g < NS; g++) begin : g_rot
        localparam int I = g - 1;
        logic signed [XW-1:0] xs, ys, n_x, n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            xs = r_x[g-1] >>> I;
            ys = r_y[g-1] >>> I;
            if (r_y[g-1] > 0) begin
                n_x = r_x[g-1] + ys;
                n_y = r_y[g-1] - xs;
                n_z = r_z[g-1] + ATAN_TAB[I];
            end else begin
                n_x = r_x[g-1] - ys;
                n_y = r_y[g-1] + xs;
                n_z = r_z[g-1] - ATAN_TAB[I];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[g]    <= n_x;
            r_y[g]    <= n_y;
            r_z[g]    <= n_z;
            r_zero[g] <= r_zero[g-1];
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_angle = r_zero[NS-1] ? '0 : r_z[NS-1];
endmodule

>>> rtl/qrp_checker.sv
module qrp_checker import qrp_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_valid,
    input logic signed [ROLL_W-1:0]  o_roll_command,
    input logic signed [PITCH_W-1:0] o_pitch_command
);
    // every result comes from an item taken a fixed latency earlier
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without an item");

    a_lossless: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n, PIPE_LATENCY) && $past(start && !busy, PIPE_LATENCY)
        && $past(i_rst_n, PIPE_LATENCY - 1) |-> o_valid)
        else $error("item lost");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_command <= 16'sd25736) && (o_roll_command >= -16'sd25736))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_command <= 15'sd12868) && (o_pitch_command >= -15'sd12868))
        else $error("pitch out of range");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind quaternion_to_roll_pitch_unit qrp_checker u_qrp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_roll_command  (o_roll_command),
    .o_pitch_command (o_pitch_command)
);
